### design/bhd_pkg.sv
// shared types, op codes and defaults for the byte histogram block
package bhd_pkg;

   localparam int SYMBOLS_DEFAULT     = 256;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int OUT_COUNT_W         = 32;
   localparam int TOTAL_W             = 32;
   localparam int DISTINCT_W          = 9;

   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_SCAN  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [7:0]             symbol_out;
      logic [OUT_COUNT_W-1:0] count;
      logic [DISTINCT_W-1:0]  distinct_count;
      logic [TOTAL_W-1:0]     total_bytes;
      logic                   last;
      logic                   none_left;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CNT_READ,
      ST_CNT_UPDATE,
      ST_SCAN_FIRST,
      ST_SCAN_NEXT,
      ST_MISC
   } state_type;

   typedef enum logic [2:0] {
      RES_COUNT,
      RES_FOUND,
      RES_NONE,
      RES_CLEAR,
      RES_PLAIN
   } res_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         scan_start;
      logic         scan_step;
      logic         scan_hit;
      logic         rd_sym;
      logic         emit;
      res_kind_type emit_kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic [1:0] cur_op;
      logic       p_end;
      logic       p_hit;
      logic       slot_free;
   } status_type;

endpackage

### design/byte_histogram_distinct_top.sv
// top level of the byte frequency histogram
//
// req channel carries one operation: count a byte, read the next symbol
// with a nonzero count, clear everything, or a no-op. every operation
// returns exactly one item on the rsp channel, in order.
// one operation is worked on at a time; req_ready is high while the
// sequencer is idle. a finished result sits in an output register, so a
// new request can be taken while the previous result waits on rsp_ready.
// count reads the store, then does the saturating update and write back;
// clear and no-op go straight to emitting their result. scan walks the
// per-symbol valid bits one symbol a cycle, from the scan pointer to the
// hit and on to the next hit or the end.
// the sequencer goes back to idle after each operation before it takes
// the next request.
// reset clears all valid bits, totals and the scan pointer; the count
// store needs no clearing pass. a stalled receiver holds the result and
// keeps the sequencer waiting in its final state.
module byte_histogram_distinct_top import bhd_pkg::*; #(
   parameter int SYMBOLS     = SYMBOLS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   bhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bhd_datapath #(
      .SYMBOLS     (SYMBOLS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### design/bhd_ctrl.sv
// sequencing state machine for count, scan, clear and no-op operations
module bhd_ctrl import bhd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (status.req_op)
                  OP_COUNT: state_in = ST_CNT_READ;
                  OP_SCAN:  state_in = ST_SCAN_FIRST;
                  default:  state_in = ST_MISC;
               endcase
            end
         end
         ST_CNT_READ: begin
            state_in = ST_CNT_UPDATE;
         end
         ST_CNT_UPDATE: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         ST_SCAN_FIRST: begin
            if (status.p_end) begin
               if (status.slot_free) state_in = ST_IDLE;
            end else if (status.p_hit) begin
               state_in = ST_SCAN_NEXT;
            end
         end
         ST_SCAN_NEXT: begin
            if ((status.p_end || status.p_hit) && status.slot_free) state_in = ST_IDLE;
         end
         ST_MISC: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.emit_kind = RES_PLAIN;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.scan_start = (status.req_op == OP_SCAN);
            end
         end
         ST_CNT_READ: begin
            cmd.rd_sym = 1'b1;
         end
         ST_CNT_UPDATE: begin
            cmd.emit      = status.slot_free;
            cmd.emit_kind = RES_COUNT;
         end
         ST_SCAN_FIRST: begin
            if (status.p_end) begin
               cmd.emit      = status.slot_free;
               cmd.emit_kind = RES_NONE;
            end else if (status.p_hit) begin
               cmd.scan_hit = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SCAN_NEXT: begin
            if (status.p_end || status.p_hit) begin
               cmd.emit      = status.slot_free;
               cmd.emit_kind = RES_FOUND;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MISC: begin
            cmd.emit      = status.slot_free;
            cmd.emit_kind = (status.cur_op == OP_CLEAR) ? RES_CLEAR : RES_PLAIN;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### design/bhd_datapath.sv
// count store, totals, scan pointer and result register
module bhd_datapath import bhd_pkg::*; #(
   parameter int SYMBOLS     = SYMBOLS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int SYM_W = $clog2(SYMBOLS);
   localparam int PTR_W = $clog2(SYMBOLS + 1);
   localparam int EXT_W = COUNT_WIDTH + OUT_COUNT_W;

   logic [COUNT_WIDTH-1:0] mem [SYMBOLS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [SYMBOLS-1:0]     valid_ff;
   logic [SYMBOLS-1:0]     valid_in;
   logic [1:0]             op_ff;
   logic [7:0]             sym_ff;
   logic [7:0]             sym_in;
   logic [PTR_W-1:0]       p_ff;
   logic [PTR_W-1:0]       p_in;
   logic [PTR_W-1:0]       scan_ptr_ff;
   logic [PTR_W-1:0]       scan_ptr_in;
   logic [DISTINCT_W-1:0]  distinct_ff;
   logic [DISTINCT_W-1:0]  distinct_in;
   logic [TOTAL_W-1:0]     total_ff;
   logic [TOTAL_W-1:0]     total_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [SYM_W-1:0]       sym_idx;
   logic [SYM_W-1:0]       p_idx;
   logic [SYM_W-1:0]       rd_addr;
   logic                   in_range;
   logic                   was_seen;
   logic                   p_end;
   logic [COUNT_WIDTH-1:0] old_cnt;
   logic [COUNT_WIDTH-1:0] new_cnt;
   logic                   do_write;
   logic [EXT_W-1:0]       new_ext;
   logic [EXT_W-1:0]       rd_ext;
   logic [OUT_COUNT_W-1:0] new_clamp;
   logic [OUT_COUNT_W-1:0] rd_clamp;

   assign sym_idx  = sym_ff[SYM_W-1:0];
   assign p_idx    = p_ff[SYM_W-1:0];
   assign rd_addr  = cmd.scan_hit ? p_idx : sym_idx;
   assign in_range = ({1'b0, sym_ff} < DISTINCT_W'(SYMBOLS));
   assign was_seen = in_range && valid_ff[sym_idx];
   assign p_end    = (p_ff == PTR_W'(SYMBOLS));

   // saturating increment of the stored count
   assign old_cnt  = was_seen ? rd_data_ff : '0;
   assign new_cnt  = (old_cnt == {COUNT_WIDTH{1'b1}}) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
   assign do_write = cmd.emit && (cmd.emit_kind == RES_COUNT) && in_range;

   // clamp counters to the 32-bit result field
   assign new_ext   = EXT_W'(new_cnt);
   assign rd_ext    = EXT_W'(rd_data_ff);
   assign new_clamp = (|new_ext[EXT_W-1:OUT_COUNT_W]) ? '1 : new_ext[OUT_COUNT_W-1:0];
   assign rd_clamp  = (|rd_ext[EXT_W-1:OUT_COUNT_W]) ? '1 : rd_ext[OUT_COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[sym_idx] <= new_cnt;
      end
      if (cmd.rd_sym || cmd.scan_hit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      sym_in       = sym_ff;
      p_in         = p_ff;
      scan_ptr_in  = scan_ptr_ff;
      distinct_in  = distinct_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load_req) begin
         sym_in = req_data.symbol;
      end
      if (cmd.scan_start) begin
         p_in = scan_ptr_ff;
      end
      if (cmd.scan_step) begin
         p_in = p_ff + PTR_W'(1);
      end
      if (cmd.scan_hit) begin
         sym_in      = 8'(p_ff);
         p_in        = p_ff + PTR_W'(1);
         scan_ptr_in = p_ff + PTR_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         case (cmd.emit_kind)
            RES_COUNT: begin
               if (in_range) begin
                  valid_in[sym_idx] = 1'b1;
                  if (!was_seen) distinct_in = distinct_ff + DISTINCT_W'(1);
                  if (total_ff != {TOTAL_W{1'b1}}) total_in = total_ff + TOTAL_W'(1);
                  rsp_in.count = new_clamp;
               end
               rsp_in.symbol_out = sym_ff;
            end
            RES_FOUND: begin
               rsp_in.symbol_out = sym_ff;
               rsp_in.count      = rd_clamp;
               rsp_in.last       = p_end;
            end
            RES_NONE: begin
               scan_ptr_in      = PTR_W'(SYMBOLS);
               rsp_in.none_left = 1'b1;
            end
            RES_CLEAR: begin
               valid_in    = '0;
               distinct_in = '0;
               total_in    = '0;
               scan_ptr_in = '0;
            end
            default: begin
               rsp_in.none_left = 1'b0;
            end
         endcase
         rsp_in.distinct_count = distinct_in;
         rsp_in.total_bytes    = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         scan_ptr_ff  <= '0;
         distinct_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         scan_ptr_ff  <= scan_ptr_in;
         distinct_ff  <= distinct_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_data.op;
      end
      sym_ff <= sym_in;
      p_ff   <= p_in;
      rsp_ff <= rsp_in;
   end

   assign status.req_op    = req_data.op;
   assign status.cur_op    = op_ff;
   assign status.p_end     = p_end;
   assign status.p_hit     = !p_end && valid_ff[p_idx];
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/bhd_checker.sv
// port-level assertions for the byte histogram, bound to the top level
module bhd_checker import bhd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a result not yet taken stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before transfer");

   // one operation at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // an exhausted scan reports no symbol and is never the last hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.none_left |->
         !rsp_data.last && rsp_data.count == '0 && rsp_data.symbol_out == '0)
      else $error("bad exhausted scan result");

   // no symbol seen means no nonzero count can be reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.distinct_count == '0 |-> rsp_data.count == '0)
      else $error("count without any distinct symbol");

endmodule

bind byte_histogram_distinct_top bhd_checker u_bhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/tb_top.sv
// testbench for the byte frequency histogram: directed and random op streams checked in order
module tb_top;
   import bhd_pkg::*;

   localparam int SYMBOLS     = SYMBOLS_DEFAULT;
   localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam int ITEM_GOAL   = 1700;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = SYMBOLS + 16;
   localparam int REPORT_CAP  = 20;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // predicted block state
   longint unsigned       tally [SYMBOLS];
   logic [DISTINCT_W-1:0] distinct_now;
   logic [TOTAL_W-1:0]    bytes_now;
   int                    scan_from;
   rsp_type               expected_rsp [$];

   int mismatches;
   int items_sent;
   int results_seen;
   int op_sent [4];
   int scan_misses;
   int peak_distinct;
   int quiet_cycles;
   int hold_asked;
   int hold_taken;
   int req_burst;
   int rsp_burst;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_histogram_distinct_top #(
      .SYMBOLS(SYMBOLS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [OUT_COUNT_W-1:0] count_field(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? {OUT_COUNT_W{1'b1}} : OUT_COUNT_W'(v);
   endfunction

   function automatic void tally_clear();
      foreach (tally[i]) tally[i] = 0;
      distinct_now = '0;
      bytes_now    = '0;
      scan_from    = 0;
   endfunction

   function automatic rsp_type tally_apply(req_type item);
      rsp_type r;
      int      s;
      int      t;
      r = '0;
      case (item.op)
         OP_COUNT: begin
            r.symbol_out = item.symbol;
            if (item.symbol < SYMBOLS) begin
               if (tally[item.symbol] == 0) distinct_now++;
               if (tally[item.symbol] < TALLY_MAX) tally[item.symbol]++;
               if (bytes_now != '1) bytes_now++;
               r.count = count_field(tally[item.symbol]);
            end
         end
         OP_SCAN: begin
            s = scan_from;
            while (s < SYMBOLS && tally[s] == 0) s++;
            if (s >= SYMBOLS) begin
               scan_from   = SYMBOLS;
               r.none_left = 1'b1;
               scan_misses++;
            end else begin
               t = s + 1;
               while (t < SYMBOLS && tally[t] == 0) t++;
               scan_from    = s + 1;
               r.symbol_out = 8'(s);
               r.count      = count_field(tally[s]);
               r.last       = (t >= SYMBOLS);
            end
         end
         OP_CLEAR: tally_clear();
         default: ;
      endcase
      r.distinct_count = distinct_now;
      r.total_bytes    = bytes_now;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [7:0] sym);
      int      gap;
      req_type item;
      gap         = draw_wait(req_burst);
      item.op     = op;
      item.symbol = sym;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(tally_apply(item));
      items_sent++;
      op_sent[op]++;
      if (distinct_now > peak_distinct) peak_distinct = distinct_now;
   endtask

   task automatic test_empty_store();
      send_op(OP_SCAN, 8'h00);
      send_op(OP_SCAN, 8'hFF);
      send_op(OP_NOP, 8'h00);
      send_op(OP_CLEAR, 8'h00);
   endtask

   task automatic test_extremes();
      send_op(OP_COUNT, 8'h00);
      send_op(OP_COUNT, 8'hFF);
      send_op(OP_COUNT, 8'h00);
      send_op(OP_COUNT, 8'h55);
      send_op(OP_COUNT, 8'hAA);
      repeat (5) send_op(OP_SCAN, 8'h00);
      // pointer stays at the end until a clear, counting does not rewind it
      send_op(OP_COUNT, 8'h01);
      send_op(OP_SCAN, 8'h00);
      send_op(OP_CLEAR, 8'hFF);
      send_op(OP_SCAN, 8'hFF);
      send_op(OP_COUNT, 8'h80);
      send_op(OP_SCAN, 8'h00);
      send_op(OP_NOP, 8'hFF);
   endtask

   task automatic test_full_alphabet();
      int i;
      send_op(OP_CLEAR, 8'h00);
      for (i = 0; i < SYMBOLS; i++) send_op(OP_COUNT, 8'(i));
      for (i = 0; i < 16; i++) send_op(OP_COUNT, 8'($urandom));
      for (i = 0; i <= SYMBOLS; i++) send_op(OP_SCAN, 8'($urandom));
   endtask

   task automatic test_backpressure();
      int i;
      hold_asked <= hold_asked + 1;
      for (i = 0; i < 16; i++) send_op((i % 3 == 1) ? OP_SCAN : OP_COUNT, 8'($urandom));
   endtask

   task automatic test_sessions(input int goal);
      int n;
      int i;
      int base;
      int span;
      int walks;
      while (items_sent < goal) begin
         if ($urandom_range(0, 3) != 0) send_op(OP_CLEAR, 8'($urandom));
         base = $urandom_range(0, 255);
         case ($urandom_range(0, 3))
            0: span = 255;
            1: span = $urandom_range(0, 7);
            2: span = $urandom_range(8, 63);
            default: span = 0;
         endcase
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_op(2'($urandom_range(0, 3)), 8'($urandom));
            else
               send_op(OP_COUNT, 8'((base + $urandom_range(0, span)) % 256));
         end
         if ($urandom_range(0, 3) == 0)
            walks = $urandom_range(0, distinct_now);
         else
            walks = distinct_now + 1;
         for (i = 0; i < walks; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_op(OP_COUNT, 8'($urandom));
            else
               send_op(OP_SCAN, 8'($urandom));
         end
      end
   endtask

   initial begin : rsp_side
      int      gap;
      rsp_type want;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_wait(rsp_burst);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("result with nothing expected, symbol_out", rsp_data.symbol_out, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.symbol_out !== want.symbol_out)
               report_mismatch("symbol_out", rsp_data.symbol_out, want.symbol_out);
            if (rsp_data.count !== want.count)
               report_mismatch("count", rsp_data.count, want.count);
            if (rsp_data.distinct_count !== want.distinct_count)
               report_mismatch("distinct_count", rsp_data.distinct_count, want.distinct_count);
            if (rsp_data.total_bytes !== want.total_bytes)
               report_mismatch("total_bytes", rsp_data.total_bytes, want.total_bytes);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
            if (rsp_data.none_left !== want.none_left)
               report_mismatch("none_left", rsp_data.none_left, want.none_left);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("[byte_histogram_distinct_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      tally_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_extremes();
      test_full_alphabet();
      test_sessions(ITEM_GOAL / 2);
      test_backpressure();
      test_sessions(ITEM_GOAL);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d ops: %0d counts, %0d scans, %0d clears, %0d no-ops",
               items_sent, op_sent[OP_COUNT], op_sent[OP_SCAN], op_sent[OP_CLEAR],
               op_sent[OP_NOP]);
      $display("checked %0d results, %0d scans ran dry, peak of %0d distinct symbols",
               results_seen, scan_misses, peak_distinct);
      if (mismatches == 0) begin
         $display("[byte_histogram_distinct_top] OK");
      end else begin
         $display("[byte_histogram_distinct_top] ERROR");
      end
      $finish;
   end

endmodule
